[rtl/core/spaq_pkg.sv]
// ============================================================================
// spaq_pkg: shared types and constants of the sorted array priority queue
// Word formats, status codes, result kinds, controller states and the
// command and status bundles between controller and datapath.
// ============================================================================
`default_nettype none

package spaq_pkg;

    localparam int DEPTH_DEFAULT = 128;

    localparam logic       REQ_INSERT = 1'b0;
    localparam logic       REQ_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] value;
    } req_word_t;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic [1:0]         status;
        logic [7:0]         count;
        logic               is_empty;
    } rsp_word_t;

    typedef enum logic [1:0] {
        RES_INSERTED,
        RES_FULL,
        RES_EMPTY,
        RES_POPPED
    } res_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_INS_READ,
        ST_INS_CMP,
        ST_POP_TAKE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic      load;
        logic      rd_prev;
        logic      rd_head;
        logic      shift;
        logic      place;
        logic      pop;
        logic      set_res;
        res_kind_t res_kind;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic req_is_pop;
        logic full;
        logic empty;
        logic pos_zero;
        logic prev_gt;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

[rtl/core/spaq_ctrl.sv]
// ============================================================================
// spaq_ctrl: request sequencer of the sorted array priority queue
// Steps one request at a time through its read, compare, shift and result
// phases by commanding the datapath.
// ============================================================================
`default_nettype none

module spaq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire spaq_pkg::sts_t sts,
    output spaq_pkg::cmd_t     cmd
);
    import spaq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.res_kind = RES_INSERTED;
        req_stall    = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                priority if (sts.req_is_pop && sts.empty)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = RES_EMPTY;
                    state_next   = ST_EMIT;
                end
                else if (sts.req_is_pop)
                begin
                    cmd.rd_head = 1'b1;
                    state_next  = ST_POP_TAKE;
                end
                else if (sts.full)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = RES_FULL;
                    state_next   = ST_EMIT;
                end
                else if (sts.pos_zero)
                begin
                    cmd.place    = 1'b1;
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = RES_INSERTED;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    state_next = ST_INS_READ;
                end
            end
            ST_INS_READ:
            begin
                cmd.rd_prev = 1'b1;
                state_next  = ST_INS_CMP;
            end
            ST_INS_CMP:
            begin
                if (sts.prev_gt)
                begin
                    cmd.shift  = 1'b1;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cmd.place    = 1'b1;
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = RES_INSERTED;
                    state_next   = ST_EMIT;
                end
            end
            ST_POP_TAKE:
            begin
                cmd.pop      = 1'b1;
                cmd.set_res  = 1'b1;
                cmd.res_kind = RES_POPPED;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/spaq_dpath.sv]
// ============================================================================
// spaq_dpath: storage and datapath of the sorted array priority queue
// Holds the sorted entries in a circular memory, the head pointer, the entry
// count, the insert cursor and the registered result word.
// ============================================================================
`default_nettype none

module spaq_dpath #(
    parameter int DEPTH = spaq_pkg::DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire spaq_pkg::req_word_t req,
    input  wire spaq_pkg::cmd_t    cmd,
    output spaq_pkg::sts_t         sts,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output spaq_pkg::rsp_word_t    rsp
);
    import spaq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [31:0] mem [DEPTH];

    logic [AW-1:0]      head_reg;
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      pos_reg;
    logic signed [31:0] val_reg;
    logic               pop_req_reg;
    logic [31:0]        rd_data_reg;
    res_kind_t          res_kind_reg;
    logic signed [31:0] res_value_reg;
    logic               rsp_valid_reg;
    rsp_word_t          rsp_reg;
    rsp_word_t          rsp_next;

    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [31:0]   wr_data;
    logic          wr_en;
    logic          rd_en;
    logic [31:0]   count_wide;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, idx};
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    assign wr_en   = cmd.shift || cmd.place;
    assign wr_addr = phys(head_reg, pos_reg);
    assign wr_data = cmd.shift ? rd_data_reg : val_reg;
    assign rd_en   = cmd.rd_prev || cmd.rd_head;
    assign rd_addr = cmd.rd_head ? head_reg : phys(head_reg, pos_reg - AW'(1));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.place)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.pop)
            begin
                count_reg <= count_reg - CW'(1);
                head_reg  <= (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
            end
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg     <= req.value;
            pop_req_reg <= (req.req_type == REQ_REMOVE);
            pos_reg     <= count_reg[AW-1:0];
        end
        else if (cmd.shift)
        begin
            pos_reg <= pos_reg - AW'(1);
        end
        if (cmd.set_res)
        begin
            res_kind_reg  <= cmd.res_kind;
            res_value_reg <= $signed(rd_data_reg);
        end
        if (cmd.out_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign count_wide = 32'(count_reg);

    always_comb
    begin
        rsp_next          = '0;
        rsp_next.count    = count_wide[7:0];
        rsp_next.is_empty = (count_reg == '0);
        unique case (res_kind_reg)
            RES_INSERTED:
            begin
                rsp_next.out_value = '0;
                rsp_next.status    = STATUS_OK;
            end
            RES_FULL:
            begin
                rsp_next.out_value = '0;
                rsp_next.status    = STATUS_FULL;
            end
            RES_EMPTY:
            begin
                rsp_next.out_value = EMPTY_VALUE;
                rsp_next.status    = STATUS_EMPTY;
            end
            RES_POPPED:
            begin
                rsp_next.out_value = res_value_reg;
                rsp_next.status    = STATUS_OK;
            end
            default:
            begin
                rsp_next.out_value = '0;
                rsp_next.status    = STATUS_OK;
            end
        endcase
    end

    assign sts.req_is_pop = pop_req_reg;
    assign sts.full       = (count_reg == DEPTH_C);
    assign sts.empty      = (count_reg == '0);
    assign sts.pos_zero   = (pos_reg == '0);
    assign sts.prev_gt    = ($signed(rd_data_reg) > val_reg);
    assign sts.out_free   = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count exceeds the depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, head_reg} < DEPTH_W)
        else $error("head pointer outside the store");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> count_reg != '0)
        else $error("removal from an empty store");

    a_place_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.place |-> count_reg != DEPTH_C)
        else $error("insert into a full store");

    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(rsp_valid_reg && rsp_stall))
        else $error("result word overwritten while stalled");
`endif

endmodule

`default_nettype wire

[rtl/core/sorted_array_priority_queue.sv]
// ============================================================================
// sorted_array_priority_queue: minimum priority queue on a sorted store
// A request word on req either inserts a signed value or removes the smallest
// entry; each request gives one response word on rsp with the removed value,
// a status code, the entry count after the request and an empty flag.
// Equal values leave in arrival order. Entries sit in a circular memory of
// DEPTH words, so a removal only advances the head pointer, while an insert
// walks from the tail toward the head, moving one larger entry up per step.
// The single memory read port serialises the work: a refused insert or an
// empty removal is answered from the decision state, a removal first reads
// the head, and an insert reads, compares and moves one entry per step until
// it stops behind a smaller or equal entry or lands at the head, directly
// when the queue is empty. One request is in work at a time; the next is
// accepted the cycle after its response is registered. The response register
// lets a new request start while the previous response still waits under
// rsp_stall; a finished response waits in the block until the register frees.
// Reset empties the queue and drops any pending response; memory contents
// are not cleared, since only written entries are ever read.
// ============================================================================
`default_nettype none

module sorted_array_priority_queue #(
    parameter int DEPTH = spaq_pkg::DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire spaq_pkg::req_word_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output spaq_pkg::rsp_word_t    rsp
);
    import spaq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    spaq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    spaq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
